/* hdl/mnp_pkg.sv */
// Shared types, sizes and helpers for the MIDI note pairing core.
package mnp_pkg;

  // Sizing
  localparam int PITCHES   = 128;
  localparam int TIME_BITS = 32;
  localparam int PITCH_W   = $clog2(PITCHES);
  localparam int NOTE_W    = 7;
  localparam int VEL_W     = 7;
  localparam int DELTA_W   = 28;
  localparam int ETYPE_W   = 2;
  localparam int TICK_W    = 32;
  localparam int SUM_W     = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;

  // Field codes
  typedef enum logic {
    ITEM_EVENT = 1'b0,
    ITEM_CLOSE = 1'b1
  } item_kind_e;

  typedef enum logic [ETYPE_W-1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_DAMPER   = 2'd2
  } ev_type_e;

  typedef enum logic {
    SPAN_NOTE   = 1'b0,
    SPAN_DAMPER = 1'b1
  } span_kind_e;

  localparam logic [NOTE_W-1:0] DAMPER_UP   = 7'd0;
  localparam logic [NOTE_W-1:0] DAMPER_DOWN = 7'd1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [PITCH_W-1:0]   pitch_idx_t;

  // One open-note entry of the table
  typedef struct packed {
    time_t            start;
    logic [VEL_W-1:0] volume;
  } note_entry_t;

  // Table access for one accepted word; the pitch index travels on its own port
  typedef struct packed {
    logic        rd;
    logic        set;
    logic        clr;
    note_entry_t wdata;
  } tbl_req_t;

  // Low bits of a time value, zero-extended when the time is narrow
  function automatic logic [TICK_W-1:0] tick_lo(time_t t);
    logic [TIME_BITS+TICK_W-1:0] w;
    w = {{TICK_W{1'b0}}, t};
    return w[TICK_W-1:0];
  endfunction

  // Pitch fits in the table
  function automatic logic pitch_in_range(logic [NOTE_W-1:0] p);
    return ({2'b00, p} < 9'(PITCHES));
  endfunction

endpackage

/* hdl/mnp_note_table.sv */
// Open-note table: valid flags in flops, start and volume in a synchronous RAM.
module mnp_note_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mnp_pkg::pitch_idx_t  idx_i,
  input  mnp_pkg::tbl_req_t    req_i,
  output logic                 hit_o,
  output mnp_pkg::note_entry_t rd_data_o
);
  import mnp_pkg::*;

  logic [PITCHES-1:0] valid_q;
  note_entry_t        mem [PITCHES];
  note_entry_t        rd_q;

  // Open flag of the addressed pitch
  assign hit_o = valid_q[idx_i];

  // Valid flags, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (req_i.set) begin
        valid_q[idx_i] <= 1'b1;
      end
      if (req_i.clr) begin
        valid_q[idx_i] <= 1'b0;
      end
    end
  end

  // Payload RAM, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.set) begin
      mem[idx_i] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rd_q <= mem[idx_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* hdl/midi_event_to_note_pairing_core.sv */
// Top level: pairs note on/off and damper events into timed spans.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_stall_o   | kind, delta_ticks, event_type, pitch, vel
//  out     | output    | out_valid_o/out_stall_i | span kind/pitch/volume, start, stop, last
//
// An item is taken every cycle when it yields at most one span and the output is not
// stalled; an item that yields two spans (close with open damper and open note) holds
// the input while its first span moves, as the output register moves one word a cycle.
// Path of a span: table access on accept, RAM read, then output register.
// Reset clears time, damper state and all note valid flags at once; no sweep.
// Output stall holds the output word and backs up into the input stall.
module midi_event_to_note_pairing_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [mnp_pkg::DELTA_W-1:0]   delta_ticks_i,
  input  logic [mnp_pkg::ETYPE_W-1:0]   event_type_i,
  input  logic [mnp_pkg::NOTE_W-1:0]    note_or_pedal_i,
  input  logic [mnp_pkg::VEL_W-1:0]     velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          span_kind_o,
  output logic [mnp_pkg::NOTE_W-1:0]    span_pitch_o,
  output logic [mnp_pkg::VEL_W-1:0]     span_volume_o,
  output logic [mnp_pkg::TICK_W-1:0]    start_ticks_o,
  output logic [mnp_pkg::TICK_W-1:0]    stop_ticks_o,
  output logic                          last_o
);
  import mnp_pkg::*;

  // Architectural state
  time_t now_q, now_d;
  logic  damper_open_q, damper_open_d;
  time_t damper_start_q, damper_start_d;

  // Span stage (after table read)
  logic              dmp_pend_q, note_pend_q;
  time_t             s1_now_q, s1_dmp_start_q;
  logic [NOTE_W-1:0] s1_pitch_q;

  // Output register
  logic              out_valid_q;
  logic              span_kind_q;
  logic [NOTE_W-1:0] span_pitch_q;
  logic [VEL_W-1:0]  span_volume_q;
  logic [TICK_W-1:0] start_ticks_q, stop_ticks_q;
  logic              last_q;

  logic        in_acc, out_free, move;
  logic        pitch_ok, hit;
  logic [SUM_W-1:0] sum;
  time_t       now_sat, stop_time;
  logic        dmp_close, note_close, note_open, dmp_open;
  pitch_idx_t  tbl_idx;
  tbl_req_t    tbl_req;
  note_entry_t rd_data;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = out_free && (dmp_pend_q || note_pend_q);
  assign in_stall_o = !((!dmp_pend_q && !note_pend_q) ||
                        (out_free && !(dmp_pend_q && note_pend_q)));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Saturating time advance
  assign sum      = SUM_W'(now_q) + SUM_W'(delta_ticks_i);
  assign now_sat  = (sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                      : sum[TIME_BITS-1:0];
  assign pitch_ok = pitch_in_range(note_or_pedal_i);

  // Decode of the incoming word
  always_comb begin
    dmp_close  = 1'b0;
    note_close = 1'b0;
    note_open  = 1'b0;
    dmp_open   = 1'b0;
    stop_time  = now_q;
    if (item_kind_e'(kind_i) == ITEM_CLOSE) begin
      dmp_close  = damper_open_q;
      note_close = pitch_ok && hit;
    end else begin
      stop_time = now_sat;
      case (ev_type_e'(event_type_i))
        EV_NOTE_ON: begin
          note_open = pitch_ok && !hit;
        end
        EV_NOTE_OFF: begin
          note_close = pitch_ok && hit;
        end
        EV_DAMPER: begin
          if (note_or_pedal_i == DAMPER_DOWN) begin
            dmp_open = !damper_open_q;
          end else if (note_or_pedal_i == DAMPER_UP) begin
            dmp_close = damper_open_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next architectural state
  always_comb begin
    now_d          = now_q;
    damper_open_d  = damper_open_q;
    damper_start_d = damper_start_q;
    if (in_acc) begin
      now_d = stop_time;
      if (dmp_open) begin
        damper_open_d  = 1'b1;
        damper_start_d = now_sat;
      end else if (dmp_close) begin
        damper_open_d = 1'b0;
      end
    end
  end

  // Table access
  assign tbl_idx = PITCH_W'(note_or_pedal_i);

  always_comb begin
    tbl_req.rd           = in_acc && note_close;
    tbl_req.clr          = in_acc && note_close;
    tbl_req.set          = in_acc && note_open;
    tbl_req.wdata.start  = now_sat;
    tbl_req.wdata.volume = velocity_i;
  end

  mnp_note_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (tbl_idx),
    .req_i     (tbl_req),
    .hit_o     (hit),
    .rd_data_o (rd_data)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q          <= '0;
      damper_open_q  <= 1'b0;
      damper_start_q <= '0;
      dmp_pend_q     <= 1'b0;
      note_pend_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      now_q          <= now_d;
      damper_open_q  <= damper_open_d;
      damper_start_q <= damper_start_d;
      if (in_acc) begin
        dmp_pend_q  <= dmp_close;
        note_pend_q <= note_close;
      end else if (move) begin
        if (dmp_pend_q) begin
          dmp_pend_q <= 1'b0;
        end else begin
          note_pend_q <= 1'b0;
        end
      end
      if (out_free) begin
        out_valid_q <= dmp_pend_q || note_pend_q;
      end
    end
  end

  // Span stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_now_q       <= stop_time;
      s1_dmp_start_q <= damper_start_q;
      s1_pitch_q     <= note_or_pedal_i;
    end
  end

  // Output word: damper span first, then note span
  always_ff @(posedge clk_i) begin
    if (move) begin
      last_q       <= !(dmp_pend_q && note_pend_q);
      stop_ticks_q <= tick_lo(s1_now_q);
      if (dmp_pend_q) begin
        span_kind_q   <= SPAN_DAMPER;
        span_pitch_q  <= '0;
        span_volume_q <= '0;
        start_ticks_q <= tick_lo(s1_dmp_start_q);
      end else begin
        span_kind_q   <= SPAN_NOTE;
        span_pitch_q  <= s1_pitch_q;
        span_volume_q <= rd_data.volume;
        start_ticks_q <= tick_lo(rd_data.start);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign span_kind_o   = span_kind_q;
  assign span_pitch_o  = span_pitch_q;
  assign span_volume_o = span_volume_q;
  assign start_ticks_o = start_ticks_q;
  assign stop_ticks_o  = stop_ticks_q;
  assign last_o        = last_q;

  // Checks
  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (now_q >= $past(now_q)))
    else $error("tick time went backwards");

  a_stall_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (dmp_pend_q || note_pend_q))
    else $error("input stalled with nothing pending");

  a_second_span_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("second span of an item missing");

endmodule
